// File: hdl/dcs_pkg.sv
`default_nettype none
package dcs_pkg;

  typedef enum logic [1:0] {
    REG_PLAYER_X    = 2'd0,
    REG_PLAYER_Y    = 2'd1,
    REG_DOOR_WIDTH  = 2'd2,
    REG_DOOR_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 112;

  // Fields of a cast item that travel past the door map.
  typedef struct packed {
    logic        [23:0] side_dist_x;
    logic        [23:0] side_dist_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic        [11:0] screen_column;
  } cast_t;

  typedef struct packed {
    logic clearing;
    logic skid_full;
  } map_stat_t;

  // Texture sizes of zero act as one, sizes above 256 act as 256.
  function automatic logic [8:0] tex_size(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0) r = 9'd1;
    else if (v > 9'd256) r = 9'd256;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dcs_delay.sv
`default_nettype none
module dcs_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic         vld_in,
  input  wire logic [W-1:0] data_in,
  output logic              vld_out,
  output logic      [W-1:0] data_out
);

  logic [N-1:0] vld_r;
  logic [W-1:0] data_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r[0] <= data_in;
      for (int i = 1; i < N; i++) data_r[i] <= data_r[i-1];
    end
  end

  assign vld_out  = vld_r[N-1];
  assign data_out = data_r[N-1];

endmodule
`default_nettype wire

// File: hdl/dcs_div.sv
`default_nettype none
module dcs_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 16,
  parameter int Q_W   = 25
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_s [Q_W+1];
  logic [DEN_W-1:0] den_s [Q_W+1];
  logic [Q_W-1:0]   quo_s [Q_W+1];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int SH = Q_W - 1 - k;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rext;
    logic          ge;
    logic [CW-1:0] rnew;

    always_comb begin
      dsh  = CW'(den_s[k]) << SH;
      rext = CW'(rem_s[k]);
      ge   = rext >= dsh;
      rnew = ge ? rext - dsh : rext;
    end

    logic [NUM_W-1:0] rem_r;
    logic [DEN_W-1:0] den_r;
    logic [Q_W-1:0]   quo_r;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rnew[NUM_W-1:0];
        den_r <= den_s[k];
        quo_r <= {quo_s[k][Q_W-2:0], ge};
      end
    end

    assign rem_s[k+1] = rem_r;
    assign den_s[k+1] = den_r;
    assign quo_s[k+1] = quo_r;
  end

  assign quo = quo_s[Q_W];

endmodule
`default_nettype wire

// File: hdl/dcs_map.sv
`default_nettype none
module dcs_map #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic                              in_tuser,
  input  wire logic [dcs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   cast_vld,
  output logic                                   cast_hit,
  output dcs_pkg::cast_t                         cast_item,
  output dcs_pkg::map_stat_t                     stat
);
  import dcs_pkg::*;

  localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic                 clr_busy_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 skid_full_r;
  logic                 skid_user_r;
  logic [IN_DATA_W-1:0] skid_data_r;

  logic                 src_vld;
  logic                 src_user;
  logic [IN_DATA_W-1:0] src_data;
  logic                 in_fire;
  logic signed [7:0]    cx;
  logic signed [7:0]    cy;
  logic                 on_map;
  logic [AW-1:0]        addr;
  cast_t                src_item;

  logic                 v0_r, mode0_r, door0_r, on_map0_r;
  logic [AW-1:0]        addr0_r;
  cast_t                item0_r;
  logic                 v1_r, on_map1_r, rd1_r;
  cast_t                item1_r;
  logic                 mem [DEPTH];

  assign in_tready = !skid_full_r && !clr_busy_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    src_vld  = skid_full_r || in_fire;
    src_user = skid_full_r ? skid_user_r : in_tuser;
    src_data = skid_full_r ? skid_data_r : in_tdata;
    cx       = $signed(src_data[7:0]);
    cy       = $signed(src_data[15:8]);
    on_map   = !cx[7] && (9'(unsigned'(cx)) < 9'(MAP_WIDTH)) &&
               !cy[7] && (9'(unsigned'(cy)) < 9'(MAP_HEIGHT));
    addr     = AW'(32'(cy[6:0]) * MAP_WIDTH + 32'(cx[6:0]));
    src_item.side_dist_x   = src_data[40:17];
    src_item.side_dist_y   = src_data[64:41];
    src_item.dir_x         = $signed(src_data[82:65]);
    src_item.dir_y         = $signed(src_data[100:83]);
    src_item.screen_column = src_data[112:101];
  end

  // Skid register: an item taken while the pipeline stalls waits here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (en) begin
      skid_full_r <= 1'b0;
    end else if (in_fire) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_user_r <= in_tuser;
      skid_data_r <= in_tdata;
    end
  end

  // After reset the map is swept clear, one cell a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (en) begin
      v0_r <= src_vld;
      v1_r <= v0_r && mode0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r   <= src_user;
      door0_r   <= src_data[16];
      on_map0_r <= on_map;
      addr0_r   <= addr;
      item0_r   <= src_item;
      on_map1_r <= on_map0_r;
      item1_r   <= item0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= 1'b0;
    end else if (en && v0_r && !mode0_r && on_map0_r) begin
      mem[addr0_r] <= door0_r;
    end
    if (en) rd1_r <= mem[addr0_r];
  end

  assign cast_vld       = v1_r;
  assign cast_hit       = on_map1_r && rd1_r;
  assign cast_item      = item1_r;
  assign stat.clearing  = clr_busy_r;
  assign stat.skid_full = skid_full_r;

endmodule
`default_nettype wire

// File: hdl/raycast_door_column_setup_unit.sv
`default_nettype none
// Door column setup for a raycaster.
// Input channel in_*: in_tuser is the mode (0 writes a door bit into a map
// cell, 1 casts one screen column). A map write gives no result; every cast
// item gives exactly one result item on out_*, whose out_tuser is the hit flag.
// On a miss, or a cell outside the map, only the column is non-zero.
// Configuration cfg_*: registers 0 to 3 are player x, player y, door width
// and door height; cfg_ready is always high. Write only while the block is idle.
// An accepted item passes 50 register stages before out_tvalid rises: two
// map stages, four selection and texture stages, the 16-stage line-length
// divider, one span stage, the 25-stage texture-step divider and two final
// stages. One item is accepted every cycle when the receiver keeps up.
// When out_tvalid is high and out_tready low, the whole pipeline holds; one
// more item is taken into a skid register, and in_tready then drops until
// the pipeline moves. After reset all MAP_WIDTH * MAP_HEIGHT door map cells
// are swept clear, and in_tready stays low during the sweep.
module raycast_door_column_setup_unit #(
  parameter int MAP_WIDTH     = 64,
  parameter int MAP_HEIGHT    = 64,
  parameter int SCREEN_HEIGHT = 512
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // mode
  input  wire logic                              in_tuser,
  // cell_x, cell_y, cell_is_door, side_dist_x, side_dist_y, ray_dir_x,
  // ray_dir_y, screen_column, zero fill
  input  wire logic [dcs_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // hit
  output logic                                   out_tuser,
  // column_out, span_start, span_end, texture_column, texture_step,
  // texture_start, zero fill
  output logic [dcs_pkg::OUT_DATA_W-1:0]         out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire dcs_pkg::cfg_reg_t                 cfg_addr,
  input  wire logic [23:0]                       cfg_data
);
  import dcs_pkg::*;

  localparam int HW     = $clog2(SCREEN_HEIGHT + 1);
  localparam int NUM1_W = HW + 16;
  localparam int H_HALF = SCREEN_HEIGHT / 2;
  localparam int D1_W   = 1 + 12 + 1 + 8;
  localparam int D2_W   = 1 + 12 + 8 + 12 + 12 + 1 + 1 + 17;

  logic [23:0] player_x_r, player_y_r;
  logic [8:0]  door_width_r, door_height_r;
  logic        adv;

  logic        m_vld, m_hit;
  cast_t       m_item;
  map_stat_t   m_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r    <= '0;
      player_y_r    <= '0;
      door_width_r  <= 9'd64;
      door_height_r <= 9'd64;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_PLAYER_X:    player_x_r    <= cfg_data;
        REG_PLAYER_Y:    player_y_r    <= cfg_data;
        REG_DOOR_WIDTH:  door_width_r  <= cfg_data[8:0];
        REG_DOOR_HEIGHT: door_height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic out_tvalid_r;
  assign adv = !out_tvalid_r || out_tready;

  dcs_map #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_map (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .cast_vld(m_vld), .cast_hit(m_hit), .cast_item(m_item), .stat(m_stat)
  );

  // Side selection.
  logic               v2_r, hit2_r, sat2_r, mir2_r;
  logic [11:0]        col2_r;
  logic [23:0]        perp2_r;
  logic signed [17:0] dir2_r;
  logic [15:0]        base2_r;
  logic               vert;
  logic [23:0]        perp;

  always_comb begin
    vert = m_item.side_dist_x < m_item.side_dist_y;
    perp = vert ? m_item.side_dist_x : m_item.side_dist_y;
  end

  logic               v3_r, hit3_r, sat3_r, mir3_r;
  logic [11:0]        col3_r;
  logic [23:0]        perp3_r;
  logic [15:0]        base3_r;
  logic [31:0]        prod3_r;
  logic               v4_r, hit4_r, sat4_r, mir4_r;
  logic [11:0]        col4_r;
  logic [23:0]        perp4_r;
  logic [31:0]        frac4_r;
  logic               v5_r, hit5_r, sat5_r;
  logic [11:0]        col5_r;
  logic [23:0]        perp5_r;
  logic [7:0]         tx5_r;
  logic signed [42:0] prod;
  logic [40:0]        fw;
  logic [8:0]         w;
  logic [8:0]         txm;

  always_comb begin
    prod = $signed({1'b0, perp2_r}) * dir2_r;
    w    = tex_size(door_width_r);
    fw   = 41'(frac4_r) * 41'(w);
    txm  = mir4_r ? w - {1'b0, fw[39:32]} - 9'd1 : {1'b0, fw[39:32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v2_r <= m_vld;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit2_r  <= m_hit;
      col2_r  <= m_item.screen_column;
      perp2_r <= perp;
      sat2_r  <= perp <= 24'(SCREEN_HEIGHT);
      dir2_r  <= vert ? m_item.dir_y : m_item.dir_x;
      base2_r <= vert ? player_y_r[15:0] : player_x_r[15:0];
      mir2_r  <= vert ? (m_item.dir_x > 18'sd0) : (m_item.dir_y < 18'sd0);

      hit3_r  <= hit2_r;
      col3_r  <= col2_r;
      perp3_r <= perp2_r;
      sat3_r  <= sat2_r;
      mir3_r  <= mir2_r;
      base3_r <= base2_r;
      prod3_r <= prod[31:0];

      hit4_r  <= hit3_r;
      col4_r  <= col3_r;
      perp4_r <= perp3_r;
      sat4_r  <= sat3_r;
      mir4_r  <= mir3_r;
      frac4_r <= {base3_r, 16'h0000} + prod3_r;

      hit5_r  <= hit4_r;
      col5_r  <= col4_r;
      perp5_r <= perp4_r;
      sat5_r  <= sat4_r;
      tx5_r   <= txm[7:0];
    end
  end

  // Line length: SCREEN_HEIGHT * 2^16 / perp, only used when it fits 16 bits.
  logic [15:0]     q1;
  logic            d1_vld;
  logic [D1_W-1:0] d1_data;

  dcs_div #(.NUM_W(NUM1_W), .DEN_W(24), .Q_W(16)) u_div_len (
    .clk(clk), .en(adv),
    .num(NUM1_W'(SCREEN_HEIGHT) << 16), .den(perp5_r), .quo(q1)
  );

  dcs_delay #(.W(D1_W), .N(16)) u_dly_len (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(v5_r),
    .data_in({hit5_r, col5_r, sat5_r, tx5_r}),
    .vld_out(d1_vld), .data_out(d1_data)
  );

  // Span.
  logic               d1_hit, d1_sat;
  logic [11:0]        d1_col;
  logic [7:0]         d1_tx;
  logic [15:0]        ll;
  logic signed [17:0] ds_raw;
  logic [17:0]        ds;
  logic [17:0]        de_raw;
  logic [17:0]        de;
  logic signed [18:0] num;

  always_comb begin
    {d1_hit, d1_col, d1_sat, d1_tx} = d1_data;
    ll     = d1_sat ? 16'hFFFF : q1;
    ds_raw = $signed(18'(H_HALF)) - $signed({3'b000, ll[15:1]});
    ds     = ds_raw[17] ? 18'd0 : ds_raw;
    de_raw = 18'(H_HALF) + {3'b000, ll[15:1]};
    de     = (de_raw >= 18'(SCREEN_HEIGHT)) ? 18'(SCREEN_HEIGHT - 1) : de_raw;
    num    = $signed({ds, 1'b0}) - $signed(19'(SCREEN_HEIGHT)) +
             $signed({3'b000, ll});
  end

  logic        v6_r, hit6_r;
  logic [11:0] col6_r, ds6_r, de6_r;
  logic [7:0]  tx6_r;
  logic [15:0] ll6_r;
  logic        numpos6_r;
  logic [16:0] num6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit6_r    <= d1_hit;
      col6_r    <= d1_col;
      tx6_r     <= d1_tx;
      ll6_r     <= ll;
      ds6_r     <= ds[11:0];
      de6_r     <= de[11:0];
      numpos6_r <= num > 19'sd0;
      num6_r    <= num[16:0];
    end
  end

  // Texture step: height * 2^16 / line length.
  logic [24:0]     q2;
  logic            d2_vld;
  logic [D2_W-1:0] d2_data;

  dcs_div #(.NUM_W(25), .DEN_W(16), .Q_W(25)) u_div_step (
    .clk(clk), .en(adv),
    .num({tex_size(door_height_r), 16'h0000}), .den(ll6_r), .quo(q2)
  );

  dcs_delay #(.W(D2_W), .N(25)) u_dly_step (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(v6_r),
    .data_in({hit6_r, col6_r, tx6_r, ds6_r, de6_r, (ll6_r == 16'd0), numpos6_r,
              num6_r}),
    .vld_out(d2_vld), .data_out(d2_data)
  );

  logic        d2_hit, d2_llz, d2_numpos;
  logic [11:0] d2_col, d2_ds, d2_de;
  logic [7:0]  d2_tx;
  logic [16:0] d2_num;

  always_comb begin
    {d2_hit, d2_col, d2_tx, d2_ds, d2_de, d2_llz, d2_numpos, d2_num} = d2_data;
  end

  logic        v7_r, hit7_r;
  logic [11:0] col7_r, ds7_r, de7_r;
  logic [7:0]  tx7_r;
  logic [31:0] step7_r;
  logic [41:0] prod7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit7_r  <= d2_hit;
      col7_r  <= d2_col;
      ds7_r   <= d2_ds;
      de7_r   <= d2_de;
      tx7_r   <= d2_tx;
      step7_r <= d2_llz ? 32'hFFFF_FFFF : {7'd0, q2};
      prod7_r <= (d2_numpos && !d2_llz) ? 42'(d2_num) * 42'(q2) : 42'd0;
    end
  end

  // Output register.
  logic [31:0]           start;
  logic                  out_tuser_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  always_comb begin
    start = (prod7_r[41:33] != 9'd0) ? 32'hFFFF_FFFF : prod7_r[32:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tuser_r <= hit7_r;
      if (hit7_r) begin
        out_tdata_r <= {4'h0, start, step7_r, tx7_r, de7_r, ds7_r, col7_r};
      end else begin
        out_tdata_r <= {100'd0, col7_r};
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[107:12] == 96'd0)
    else $error("miss result carries non-zero fields");

  a_span_order : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[23:12] <= out_tdata[35:24])
    else $error("span start beyond span end");

  a_clear_block : assert property (@(posedge clk) disable iff (!rst_n)
    m_stat.clearing |-> !in_tready && !m_stat.skid_full)
    else $error("item taken during map clearing");

  a_skid_hold : assert property (@(posedge clk) disable iff (!rst_n)
    m_stat.skid_full && !adv |=> m_stat.skid_full)
    else $error("skid item lost during stall");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 100ps
module tb;
  import dcs_pkg::*;

  localparam int  SCREEN_H   = 512;
  localparam int  MAP_W      = 64;
  localparam int  MAP_H      = 64;
  localparam int  DRAIN_WAIT = 60;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] step;
    logic [7:0]  tex_col;
    logic [11:0] span_end;
    logic [11:0] span_start;
    logic [11:0] column;
  } span_t;

  typedef struct {
    logic  hit;
    span_t span;
  } span_item_t;

  class span_scoreboard;
    bit          door_map[MAP_W*MAP_H];
    logic [23:0] pos_x, pos_y;
    logic [8:0]  tex_w, tex_h;
    span_item_t  pending[$];
    int          errors;

    function new();
      pos_x = '0; pos_y = '0; tex_w = 9'd64; tex_h = 9'd64; errors = 0;
    endfunction

    function void set_reg(cfg_reg_t a, logic [23:0] v);
      case (a)
        REG_PLAYER_X:    pos_x = v;
        REG_PLAYER_Y:    pos_y = v;
        REG_DOOR_WIDTH:  tex_w = v[8:0];
        REG_DOOR_HEIGHT: tex_h = v[8:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic mode, logic [IN_DATA_W-1:0] d);
      logic signed [7:0]  scx, scy;
      logic signed [17:0] sdx, sdy;
      longint cx, cy, idx, perp, dx, dy, w, h, ll, ds, de, base, prod, tx, step, start, num;
      logic [63:0] pos;
      logic [31:0] frac;
      bit inmap, vert;
      span_item_t e;
      scx = d[7:0]; scy = d[15:8]; sdx = d[82:65]; sdy = d[100:83];
      cx = scx; cy = scy; dx = sdx; dy = sdy;
      inmap = cx >= 0 && cx < MAP_W && cy >= 0 && cy < MAP_H;
      idx = inmap ? cy * MAP_W + cx : 0;
      if (mode == 1'b0) begin
        if (inmap) door_map[idx] = d[16];
        return;
      end
      e.hit = 1'b0;
      e.span = '0;
      e.span.column = d[112:101];
      if (inmap && door_map[idx]) begin
        vert = d[40:17] < d[64:41];
        perp = vert ? longint'(d[40:17]) : longint'(d[64:41]);
        w = (tex_w == 0) ? 1 : (tex_w > 256) ? 256 : tex_w;
        h = (tex_h == 0) ? 1 : (tex_h > 256) ? 256 : tex_h;
        if (perp == 0) ll = 65535;
        else begin
          ll = (longint'(SCREEN_H) << 16) / perp;
          if (ll > 65535) ll = 65535;
        end
        ds = SCREEN_H / 2 - ll / 2;
        de = SCREEN_H / 2 + ll / 2;
        if (ds < 0) ds = 0;
        if (de >= SCREEN_H) de = SCREEN_H - 1;
        base = (vert ? longint'(pos_y) : longint'(pos_x)) << 16;
        prod = perp * (vert ? dy : dx);
        pos = base + prod;
        frac = pos[31:0];
        tx = (longint'(frac) * w) >> 32;
        if ((vert && dx > 0) || (!vert && dy < 0)) tx = w - tx - 1;
        if (ll == 0) begin
          step = 64'hFFFFFFFF;
          start = 0;
        end else begin
          step = (h << 16) / ll;
          num = 2 * ds - SCREEN_H + ll;
          if (num <= 0) start = 0;
          else begin
            start = (num * step) >> 1;
            if (start > 64'hFFFFFFFF) start = 64'hFFFFFFFF;
          end
        end
        e.hit = 1'b1;
        e.span.span_start = ds[11:0];
        e.span.span_end = de[11:0];
        e.span.tex_col = tx[7:0];
        e.span.step = step[31:0];
        e.span.start = start[31:0];
      end
      pending.push_back(e);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic hit, logic [OUT_DATA_W-1:0] d);
      span_item_t e;
      span_t a;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual hit %b data %h", $time, hit, d);
        return;
      end
      e = pending.pop_front();
      a = d[107:0];
      field("hit", 32'(e.hit), 32'(hit));
      field("column_out", 32'(e.span.column), 32'(a.column));
      field("span_start", 32'(e.span.span_start), 32'(a.span_start));
      field("span_end", 32'(e.span.span_end), 32'(a.span_end));
      field("texture_column", 32'(e.span.tex_col), 32'(a.tex_col));
      field("texture_step", e.span.step, a.step);
      field("texture_start", e.span.start, a.start);
      if (d[111:108] !== 4'b0) field("zero fill", 32'd0, 32'(d[111:108]));
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tuser = 0, out_tready = 0, cfg_valid = 0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [23:0] cfg_data = '0;
  cfg_reg_t cfg_addr = REG_PLAYER_X;
  logic in_tready, out_tvalid, out_tuser, cfg_ready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int send_pct = 0, stall_pct = 0;
  longint cycles = 0;
  span_scoreboard sb = new();

  raycast_door_column_setup_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("raycast_door_column_setup_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(logic mode, logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, d);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack(logic [7:0] cx, logic [7:0] cy, logic door,
      logic [23:0] sdx, logic [23:0] sdy, logic [17:0] dx, logic [17:0] dy, logic [11:0] col);
    return {7'b0, col, dy, dx, sdy, sdx, door, cy, cx};
  endfunction

  task automatic write_cell(logic [7:0] cx, logic [7:0] cy, logic door);
    send(1'b0, pack(cx, cy, door, 24'($urandom), 24'($urandom), 18'($urandom),
                    18'($urandom), 12'($urandom)));
  endtask

  task automatic cast(logic [7:0] cx, logic [7:0] cy, logic [23:0] sdx, logic [23:0] sdy,
      logic [17:0] dx, logic [17:0] dy, logic [11:0] col);
    send(1'b1, pack(cx, cy, 1'($urandom), sdx, sdy, dx, dy, col));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t a, logic [23:0] v);
    cfg_valid <= 1'b1;
    cfg_addr <= a;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(a, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic [7:0] cx, cy;
    logic [23:0] sdx, sdy;
    cx = ($urandom_range(99) < 85) ? 8'($urandom_range(MAP_W - 1)) : 8'($urandom);
    cy = ($urandom_range(99) < 85) ? 8'($urandom_range(MAP_H - 1)) : 8'($urandom);
    case ($urandom_range(2))
      0: begin sdx = 24'($urandom_range(255)); sdy = 24'($urandom_range(255)); end
      1: begin
        sdx = 24'($urandom_range(24'h3FFFF));
        sdy = 24'($urandom_range(24'h3FFFF));
      end
      default: begin sdx = 24'($urandom); sdy = 24'($urandom); end
    endcase
    if ($urandom_range(99) < 40)
      send(1'b0, pack(cx, cy, $urandom_range(99) < 60, sdx, sdy, 18'($urandom),
                      18'($urandom), 12'($urandom)));
    else
      send(1'b1, pack(cx, cy, 1'($urandom), sdx, sdy, 18'($urandom), 18'($urandom),
                      12'($urandom)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: map corners, writes outside the map, both sides and mirrors.
    write_cell(8'd0, 8'd0, 1'b1);
    write_cell(8'd63, 8'd63, 1'b1);
    write_cell(8'd5, 8'd7, 1'b1);
    write_cell(8'hFF, 8'd0, 1'b1);
    write_cell(8'd64, 8'd0, 1'b1);
    write_cell(8'h80, 8'd127, 1'b1);
    cast(8'd0, 8'd0, 24'd0, 24'd0, 18'h1FFFF, 18'h20000, 12'd0);
    cast(8'd63, 8'd63, 24'hFFFFFF, 24'hFFFFFF, 18'h20000, 18'h1FFFF, 12'hFFF);
    cast(8'd5, 8'd7, 24'h010000, 24'h020000, 18'h08000, 18'h3F000, 12'd1);
    cast(8'd5, 8'd7, 24'h020000, 24'h010000, 18'h3F000, 18'h38000, 12'd2);
    cast(8'd5, 8'd7, 24'h000100, 24'hFFFFFF, 18'h3FFFF, 18'h00001, 12'd3);
    cast(8'd5, 8'd7, 24'h010000, 24'h010000, 18'h0, 18'h0, 12'd4);
    cast(8'd5, 8'd7, 24'h050000, 24'hFFFFFF, 18'h10000, 18'h10000, 12'd5);
    cast(8'd1, 8'd1, 24'h010000, 24'h010000, 18'h0, 18'h0, 12'd6);
    cast(8'hFF, 8'd0, 24'h010000, 24'h010000, 18'h0, 18'h0, 12'd7);
    cast(8'd64, 8'd64, 24'h010000, 24'h010000, 18'h0, 18'h0, 12'd8);
    cast(8'h80, 8'h7F, 24'h010000, 24'h010000, 18'h0, 18'h0, 12'd9);
    write_cell(8'd5, 8'd7, 1'b0);
    cast(8'd5, 8'd7, 24'h010000, 24'h020000, 18'h0, 18'h0, 12'd10);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(REG_PLAYER_X, 24'h123456); write_reg(REG_PLAYER_Y, 24'h00ABCD);
          write_reg(REG_DOOR_WIDTH, 24'd64); write_reg(REG_DOOR_HEIGHT, 24'd63);
        end
        1: begin
          write_reg(REG_PLAYER_X, 24'hFFFFFF); write_reg(REG_PLAYER_Y, 24'hFFFFFF);
          write_reg(REG_DOOR_WIDTH, 24'd256); write_reg(REG_DOOR_HEIGHT, 24'd256);
        end
        2: begin
          write_reg(REG_PLAYER_X, 24'd0); write_reg(REG_PLAYER_Y, 24'd0);
          write_reg(REG_DOOR_WIDTH, 24'd1); write_reg(REG_DOOR_HEIGHT, 24'd1);
        end
        3: begin
          write_reg(REG_PLAYER_X, 24'($urandom)); write_reg(REG_PLAYER_Y, 24'($urandom));
          write_reg(REG_DOOR_WIDTH, 24'd0); write_reg(REG_DOOR_HEIGHT, 24'hFFFFFF);
        end
        default: begin
          write_reg(REG_PLAYER_X, 24'($urandom)); write_reg(REG_PLAYER_Y, 24'($urandom));
          write_reg(REG_DOOR_WIDTH, 24'($urandom_range(511)));
          write_reg(REG_DOOR_HEIGHT, 24'($urandom_range(511)));
        end
      endcase
      case (p)
        1: begin send_pct = 73; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 73; end
        3: begin send_pct = 29; stall_pct = 29; end
        default: begin send_pct = 0; stall_pct = 0; end
      endcase
      for (int i = 0; i < 170; i++) begin
        // Let the pipeline empty completely once mid-phase.
        if (p == 3 && i == 85) wait_idle();
        random_item();
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("raycast_door_column_setup_unit verification clean");
    else
      $display("raycast_door_column_setup_unit verification failed");
    $finish;
  end
endmodule

// File: files.f
hdl/dcs_pkg.sv
hdl/dcs_delay.sv
hdl/dcs_div.sv
hdl/dcs_map.sv
hdl/raycast_door_column_setup_unit.sv
test/tb.sv
